// File: src/actr_pkg.sv
// ----------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES helper functions for the CTR keystream block.
// ----------------------------------------------------------------------------
package actr_pkg;

  localparam int NumRounds  = 10;
  localparam int BlockBytes = 16;

  typedef logic [3:0] cfg_index_t;
  localparam cfg_index_t RegKeyUpper   = 4'd0;
  localparam cfg_index_t RegKeyLower   = 4'd1;
  localparam cfg_index_t RegNonceUpper = 4'd2;
  localparam cfg_index_t RegNonceLower = 4'd3;

  // payload carried along the chain beside the AES state
  typedef struct packed {
    logic [127:0] text;
    logic [4:0]   byte_count;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  // one AES round: SubBytes, ShiftRows, MixColumns unless last, then key add
  function automatic logic [127:0] aes_round(input logic [127:0] st,
                                             input logic [127:0] rk,
                                             input logic last);
    logic [127:0] tmp;
    logic [127:0] res;
    logic [7:0] a0, a1, a2, a3, t;
    tmp = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        tmp[127-8*(r+4*c) -: 8] = sbox(get_byte(st, r + 4*((c + r) % 4)));
      end
    end
    res = tmp;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(tmp, 4*c);
        a1 = get_byte(tmp, 4*c+1);
        a2 = get_byte(tmp, 4*c+2);
        a3 = get_byte(tmp, 4*c+3);
        t  = a0 ^ a1 ^ a2 ^ a3;
        res[127-8*(4*c)   -: 8] = a0 ^ t ^ gf_dbl(a0 ^ a1);
        res[127-8*(4*c+1) -: 8] = a1 ^ t ^ gf_dbl(a1 ^ a2);
        res[127-8*(4*c+2) -: 8] = a2 ^ t ^ gf_dbl(a2 ^ a3);
        res[127-8*(4*c+3) -: 8] = a3 ^ t ^ gf_dbl(a3 ^ a0);
      end
    end
    return res ^ rk;
  endfunction

  // next round key from the previous one and the round constant
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: src/aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor
// AES-128 counter-mode keystream XOR, one 16-byte block per item.
// ----------------------------------------------------------------------------
// Use: write key and initial counter over the cfg channel (index 0..3) while
// idle, then stream items on s_axis. Each item holds a block index, 16 data
// bytes and a count of valid leading bytes; the counter is the initial counter
// plus the block index, encrypted under the key, and XORed into the valid
// bytes. Bytes past the count come out zero; a count above 16 acts as 16.
// Stages: counter add register, ten round cells, output register. Throughput:
// one item per cycle unless the output stalls; each round cell is one AES round
// deep. The round key stages run free of the stall and each takes up a new key
// before an item sent after the write reaches its cell, so items may follow a
// key write at once; write the configuration only while nothing is in flight.
// Stall: while a full output waits on m_axis_tready the chain holds; s_axis_tready
// stays high while the output register is empty or being drained.
// Reset: clears all valid flags and the configuration registers to zero.
// ----------------------------------------------------------------------------
module aes128_ctr_keystream_xor (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // block_index[63:0], text_upper[127:64], text_lower[191:128], byte_count[196:192]
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_upper[63:0], result_lower[127:64]
  output logic [127:0] m_axis_tdata
);
  import actr_pkg::*;

  logic [63:0] key_upper, key_lower, nonce_upper, nonce_lower;
  logic [127:0] round_keys [NumRounds+1];
  logic advance;

  logic            v    [NumRounds+1];
  logic [127:0]    st   [NumRounds+1];
  side_t           side [NumRounds+1];
  logic [127:0]    ctr_sum;
  logic [127:0]    ks;
  logic [127:0]    masked;
  logic [4:0]      cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper   <= '0;
      key_lower   <= '0;
      nonce_upper <= '0;
      nonce_lower <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKeyUpper:   key_upper   <= cfg_data;
        RegKeyLower:   key_lower   <= cfg_data;
        RegNonceUpper: nonce_upper <= cfg_data;
        RegNonceLower: nonce_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_key_sched u_keys (
    .clk        (clk),
    .key        ({key_upper, key_lower}),
    .round_keys (round_keys)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // counter add and initial key add
  assign ctr_sum = {nonce_upper, nonce_lower} + {64'd0, s_axis_tdata[63:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0]              <= ctr_sum ^ round_keys[0];
      side[0].text       <= {s_axis_tdata[127:64], s_axis_tdata[191:128]};
      side[0].byte_count <= s_axis_tdata[196:192];
    end
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_cell
    actr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (v[r]),
      .in_state  (st[r]),
      .in_side   (side[r]),
      .round_key (round_keys[r+1]),
      .last      (r == NumRounds - 1),
      .out_valid (v[r+1]),
      .out_state (st[r+1]),
      .out_side  (side[r+1])
    );
  end

  assign ks  = st[NumRounds];
  assign cnt = (side[NumRounds].byte_count > 5'd16) ? 5'd16 : side[NumRounds].byte_count;

  always_comb begin
    for (int i = 0; i < BlockBytes; i++) begin
      masked[127-8*i -: 8] = (5'(i) < cnt) ?
          (side[NumRounds].text[127-8*i -: 8] ^ ks[127-8*i -: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= v[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {masked[63:0], masked[127:64]};
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_chain: assert property (@(posedge clk) disable iff (rst)
    advance && v[NumRounds] |=> m_axis_tvalid)
    else $error("item lost at output");
`endif

endmodule

// File: src/actr_cell.sv
// ----------------------------------------------------------------------------
// actr_cell
// One round cell: applies one AES round and hands state and payload on.
// ----------------------------------------------------------------------------
module actr_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  logic [127:0]    in_state,
  input  actr_pkg::side_t in_side,
  input  logic [127:0]    round_key,
  input  logic            last,
  output logic            out_valid,
  output logic [127:0]    out_state,
  output actr_pkg::side_t out_side
);
  import actr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= aes_round(in_state, round_key, last);
      out_side  <= in_side;
    end
  end

endmodule

// File: src/actr_key_sched.sv
// ----------------------------------------------------------------------------
// actr_key_sched
// Round key expansion, registered stage by stage from the key registers.
// ----------------------------------------------------------------------------
module actr_key_sched (
  input  logic         clk,
  input  logic [127:0] key,
  output logic [127:0] round_keys [actr_pkg::NumRounds+1]
);
  import actr_pkg::*;

  logic [7:0] rcon [NumRounds];
  logic [127:0] rk [NumRounds+1];

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i < NumRounds; i++) begin
      rcon[i] = gf_dbl(rcon[i-1]);
    end
  end

  assign rk[0] = key;

  for (genvar i = 0; i < NumRounds; i++) begin : g_step
    always_ff @(posedge clk) begin
      rk[i+1] <= key_step(rk[i], rcon[i]);
    end
  end

  assign round_keys = rk;

endmodule

// File: tb/tb_aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// tb_aes128_ctr_keystream_xor
// Self-checking bench for the AES-128 CTR keystream XOR stream block. Items
// are driven with random gaps and output stalls. Every result is compared
// with an independent AES-128 CTR predictor or, for typed table rows, with a
// stored value. The run covers a directed table and then random blocks under
// several key and counter settings, among them all-zero, all-one and counter-wrap.
// ----------------------------------------------------------------------------
module tb_aes128_ctr_keystream_xor;
  timeunit 1ns;
  timeprecision 1ps;
  import actr_pkg::*;

  typedef struct {
    logic [63:0]  idx;
    logic [63:0]  up;
    logic [63:0]  lo;
    logic [4:0]   cnt;
    bit           typed;
    logic [127:0] res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  cfg_index_t   cfg_index = RegKeyUpper;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [127:0] m_axis_tdata;

  logic [7:0]   sbox_lut [256];
  logic [127:0] aes_key = '0;
  logic [127:0] ctr_base = '0;
  logic [127:0] result_q [$];
  int           fail_cnt = 0;
  int           sent = 0;
  int           got = 0;
  bit           quiet = 1'b0;
  int           stall_left = 0;

  aes128_ctr_keystream_xor dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic void build_sbox();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_lut[x] = b;
    end
  endfunction

  // encrypt one block, byte 0 in the top bits
  function automatic logic [127:0] aes128_block(input logic [127:0] key,
                                                input logic [127:0] blk);
    logic [31:0]  w [44];
    logic [31:0]  t;
    logic [7:0]   rc, a0, a1, a2, a3;
    logic [7:0]   s [16];
    logic [7:0]   m [16];
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sbox_lut[t[23:16]] ^ rc, sbox_lut[t[15:8]], sbox_lut[t[7:0]],
             sbox_lut[t[31:24]]};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8] ^ w[k/4][31-8*(k%4) -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++)
          m[q+4*c] = sbox_lut[s[q+4*((c+q)%4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
          m[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          m[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          m[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          m[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      end
      for (int k = 0; k < 16; k++) s[k] = m[k] ^ w[4*r + k/4][31-8*(k%4) -: 8];
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
    return res;
  endfunction

  // returns {result_lower, result_upper} as the block packs it
  function automatic logic [127:0] ctr_xor(input logic [63:0] idx, input logic [63:0] up,
                                           input logic [63:0] lo, input logic [4:0] cnt);
    logic [127:0] ks, data;
    int n;
    ks = aes128_block(aes_key, ctr_base + {64'd0, idx});
    data = {up, lo} ^ ks;
    n = (cnt > 5'd16) ? 16 : int'(cnt);
    for (int k = 0; k < 16; k++) begin
      if (k >= n) data[127-8*k -: 8] = 8'h00;
    end
    return {data[63:0], data[127:64]};
  endfunction

  task automatic cfg_write(input cfg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      RegKeyUpper:   aes_key[127:64]  = val;
      RegKeyLower:   aes_key[63:0]    = val;
      RegNonceUpper: ctr_base[127:64] = val;
      RegNonceLower: ctr_base[63:0]   = val;
      default: ;
    endcase
  endtask

  task automatic drain(input int extra);
    while (result_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_phase(input logic [63:0] ku, input logic [63:0] kl,
                           input logic [63:0] nu, input logic [63:0] nl);
    drain(16);
    cfg_write(RegKeyUpper, ku);
    cfg_write(RegKeyLower, kl);
    cfg_write(RegNonceUpper, nu);
    cfg_write(RegNonceLower, nl);
    repeat (14) @(posedge clk);
  endtask

  task automatic send_block(input row_t r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, r.cnt, r.lo, r.up, r.idx};
    do @(posedge clk); while (!s_axis_tready);
    result_q.push_back(r.typed ? r.res : ctr_xor(r.idx, r.up, r.lo, r.cnt));
    sent++;
  endtask

  task automatic send_random(input int n);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r.idx = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: r.idx = 64'($urandom_range(0, 3));
        1: r.idx = ~64'd0 - 64'($urandom_range(0, 3));
        default: ;
      endcase
      r.up  = {$urandom, $urandom};
      r.lo  = {$urandom, $urandom};
      r.cnt = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
      if ($urandom_range(0, 4) == 0) r.cnt = 5'($urandom_range(1, 15));
      r.typed = 1'b0;
      r.res   = '0;
      send_block(r);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got++;
      if (result_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0]) begin
          $error("result_upper expected %h got %h", want[63:0], m_axis_tdata[63:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[127:64] !== want[127:64]) begin
          $error("result_lower expected %h got %h", want[127:64], m_axis_tdata[127:64]);
          fail_cnt++;
        end
      end
    end
  end

  row_t dir_tab [] = '{
    '{64'd0, 64'd0, 64'd0, 5'd16, 1'b1, {64'h884cfa59ca342b2e, 64'h66e94bd4ef8a2c3b}},
    '{64'd0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd0, 1'b1, 128'd0},
    '{64'd0, 64'd0, 64'd0, 5'd31, 1'b1, {64'h884cfa59ca342b2e, 64'h66e94bd4ef8a2c3b}},
    '{64'd0, 64'd0, 64'd0, 5'd17, 1'b1, {64'h884cfa59ca342b2e, 64'h66e94bd4ef8a2c3b}},
    '{64'd0, 64'd0, 64'd0, 5'd1, 1'b1, {64'h0, 64'h6600000000000000}},
    '{64'd0, 64'd0, 64'd0, 5'd8, 1'b1, {64'h0, 64'h66e94bd4ef8a2c3b}},
    '{64'd0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 128'd0},
    '{64'd1, 64'd0, 64'd0, 5'd16, 1'b0, 128'd0},
    '{64'hffffffffffffffff, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0, 128'd0},
    '{64'h8000000000000000, 64'hffffffffffffffff, 64'd0, 5'd15, 1'b0, 128'd0},
    '{64'd2, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd9, 1'b0, 128'd0},
    '{64'd3, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd7, 1'b0, 128'd0}
  };

  initial begin
    build_sbox();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (14) @(posedge clk);

    foreach (dir_tab[i]) send_block(dir_tab[i]);
    @(negedge clk);
    s_axis_tvalid = 1'b0;

    // counter wrap across both halves
    set_phase('1, '1, '1, '1);
    send_random(100);
    set_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              ~64'd0 - 64'($urandom_range(0, 2)));
    send_random(60);
    drain(0);
    send_random(60);
    set_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom});
    send_random(100);
    set_phase('0, '0, '0, '0);
    send_random(60);
    quiet = 1'b1;
    send_random(70);

    fork
      drain(20);
      begin
        repeat (5000) @(posedge clk);
        fail_cnt++;
        $error("results still outstanding: %0d", result_q.size());
      end
    join_any
    disable fork;
    $display("Run: %0d blocks sent, %0d results checked over five key/counter settings,",
             sent, got);
    $display("     with partial and out-of-range byte counts and counter wrap-around.");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: aes128_ctr_keystream_xor.f
src/actr_pkg.sv
src/actr_cell.sv
src/actr_key_sched.sv
src/aes128_ctr_keystream_xor.sv
tb/tb_aes128_ctr_keystream_xor.sv
